// ===== hw/rtl/lazy_add_raise_table_with_max_unit_macros.svh =====
// Assertion macros shared by the lazy add/raise table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LAZY_ADD_RAISE_TABLE_WITH_MAX_UNIT_MACROS_SVH
`define LAZY_ADD_RAISE_TABLE_WITH_MAX_UNIT_MACROS_SVH

// same-cycle implication
`define LARM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define LARM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/larm_pkg.sv =====
// Shared types, constants and helpers for the lazy add/raise table unit.
// No dependencies.
package larm_pkg;

	localparam int DATA_W        = 64;
	localparam int INDEX_W       = 10;
	localparam int DEPTH_DEFAULT = 1024;

	typedef enum logic [1:0] {
		KIND_ADD_ALL   = 2'd0,
		KIND_RAISE_ALL = 2'd1,
		KIND_ADD_AT    = 2'd2,
		KIND_RAISE_AT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NORM,
		ST_MOD,
		ST_DONE
	} state_t;

	function automatic logic signed [DATA_W-1:0] smax(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		return (a < b) ? b : a;
	endfunction

endpackage

// ===== hw/rtl/larm_if.sv =====
// Valid/ready channel interfaces for operations in and results out.
// Depends on larm_pkg for field widths.
interface larm_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [1:0]                               kind;
	logic [larm_pkg::INDEX_W-1:0]             index;
	logic signed [larm_pkg::DATA_W-1:0]       value;

	modport source (output valid, output kind, output index, output value, input ready);
	modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

interface larm_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [larm_pkg::DATA_W-1:0]       max_value;
	logic signed [larm_pkg::DATA_W-1:0]       entry_value;

	modport source (output valid, output max_value, output entry_value, input ready);
	modport sink   (input valid, input max_value, input entry_value, output ready);
endinterface

// ===== hw/rtl/larm_ram.sv =====
// Single-port-write, single-port-read entry store with registered read data.
// Depends on larm_pkg for the data width.
module larm_ram #(
	parameter int DEPTH = larm_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic [larm_pkg::DATA_W-1:0]       wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic [larm_pkg::DATA_W-1:0]       rdata
);

	logic [larm_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/lazy_add_raise_table_with_max_unit.sv =====
// Lazy add/raise table with running maximum. Each operation holds the unit for
// four steps (accept and read, normalize, modify, write back and deliver); the
// read issued at accept is registered in the entry memory and used by the
// normalize step, followed by the modify step, and no new operation is taken
// until write back and deliver is done. The unit stays in the write-back step
// while a previous result is still waiting at the output. Whole-table
// operations run through the same four steps without writing the memory.
// After reset the unit sweeps the memory to zero, one entry per cycle over all
// DEPTH entries, and takes no operation until the sweep is done.
// Depends on larm_pkg, larm_if.sv, larm_ram and the assertion macro header.
`include "lazy_add_raise_table_with_max_unit_macros.svh"

module lazy_add_raise_table_with_max_unit #(
	parameter int DEPTH = larm_pkg::DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	larm_in_if.sink    op,
	larm_out_if.source res
);

	localparam int AW = $clog2(DEPTH);
	localparam int DW = larm_pkg::DATA_W;

	larm_pkg::state_t state_q, state_d;

	larm_pkg::kind_t     kind_q;
	logic [AW-1:0]       addr_q;
	logic                inrange_q;
	logic signed [DW-1:0] val_q;

	logic signed [DW-1:0] shift_q, floor_q, rmax_q;
	logic signed [DW-1:0] r_q, t_q;
	logic [AW-1:0]       clr_q;

	logic                out_valid_q;
	logic signed [DW-1:0] out_max_q, out_entry_q;

	logic [31:0]         idx_ext;
	logic [AW-1:0]       op_addr;
	logic                op_inrange;
	logic                accept, out_free, done, point_op;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [DW-1:0]       ram_wdata, ram_rdata;

	logic signed [DW-1:0] t_max, entry_real, rmax_d, entry_d;

	assign idx_ext    = 32'(op.index);
	assign op_addr    = idx_ext[AW-1:0];
	assign op_inrange = idx_ext < 32'(DEPTH);

	assign op.ready = (state_q == larm_pkg::ST_IDLE);
	assign accept   = op.valid && op.ready;
	assign out_free = !out_valid_q || res.ready;
	assign done     = (state_q == larm_pkg::ST_DONE) && out_free;
	assign point_op = (kind_q == larm_pkg::KIND_ADD_AT) || (kind_q == larm_pkg::KIND_RAISE_AT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= larm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			larm_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = larm_pkg::ST_IDLE;
			end
			larm_pkg::ST_IDLE: begin
				if (op.valid) state_d = larm_pkg::ST_NORM;
			end
			larm_pkg::ST_NORM: state_d = larm_pkg::ST_MOD;
			larm_pkg::ST_MOD:  state_d = larm_pkg::ST_DONE;
			larm_pkg::ST_DONE: begin
				if (out_free) state_d = larm_pkg::ST_IDLE;
			end
			default: state_d = larm_pkg::ST_CLEAR;
		endcase
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == larm_pkg::ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// captured operation
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= larm_pkg::kind_t'(op.kind);
			addr_q    <= op_addr;
			inrange_q <= op_inrange;
			val_q     <= op.value;
		end
	end

	// normalize: real value of the entry under the current tags
	always_ff @(posedge clk) begin
		if (state_q == larm_pkg::ST_NORM) begin
			r_q <= larm_pkg::smax($signed(ram_rdata) + shift_q, floor_q);
		end
	end

	// modify: t_q is the entry's new real value, the new floor for a raise-all, or zero for an add-all
	always_ff @(posedge clk) begin
		if (state_q == larm_pkg::ST_MOD) begin
			unique case (kind_q)
				larm_pkg::KIND_ADD_ALL:   t_q <= '0;
				larm_pkg::KIND_RAISE_ALL: t_q <= larm_pkg::smax(floor_q, val_q);
				larm_pkg::KIND_ADD_AT:    t_q <= r_q + val_q;
				larm_pkg::KIND_RAISE_AT:  t_q <= larm_pkg::smax(val_q, r_q);
				default:                  t_q <= '0;
			endcase
		end
	end

	assign t_max      = larm_pkg::smax(rmax_q, t_q);
	assign entry_real = larm_pkg::smax(t_q, floor_q);

	always_comb begin
		rmax_d  = rmax_q;
		entry_d = '0;
		unique case (kind_q)
			larm_pkg::KIND_ADD_ALL:   rmax_d = rmax_q + val_q;
			larm_pkg::KIND_RAISE_ALL: rmax_d = t_max;
			larm_pkg::KIND_ADD_AT,
			larm_pkg::KIND_RAISE_AT: begin
				if (inrange_q) begin
					rmax_d  = t_max;
					entry_d = entry_real;
				end
			end
			default: rmax_d = rmax_q;
		endcase
	end

	// lazy tags and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			floor_q <= '0;
			rmax_q  <= '0;
		end else if (done) begin
			rmax_q <= rmax_d;
			if (kind_q == larm_pkg::KIND_ADD_ALL) begin
				shift_q <= shift_q + val_q;
				floor_q <= floor_q + val_q;
			end else if (kind_q == larm_pkg::KIND_RAISE_ALL) begin
				floor_q <= t_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_max_q   <= rmax_d;
			out_entry_q <= entry_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.max_value   = out_max_q;
	assign res.entry_value = out_entry_q;

	// stored value is real value minus shift, so a later add-all lifts it for free
	assign ram_we    = (state_q == larm_pkg::ST_CLEAR) || (done && point_op && inrange_q);
	assign ram_waddr = (state_q == larm_pkg::ST_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == larm_pkg::ST_CLEAR) ? '0 : DW'(t_q - shift_q);

	larm_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (op_addr),
		.rdata (ram_rdata)
	);

	`LARM_ASSERT_IMPL(a_no_accept_in_clear, clk, arst_n,
		state_q == larm_pkg::ST_CLEAR, !op.ready)
	`LARM_ASSERT_NEXT(a_accept_to_norm, clk, arst_n,
		accept, state_q == larm_pkg::ST_NORM)
	`LARM_ASSERT_IMPL(a_write_when_allowed, clk, arst_n,
		ram_we, (state_q == larm_pkg::ST_CLEAR) || (state_q == larm_pkg::ST_DONE))
	`LARM_ASSERT_NEXT(a_hold_while_blocked, clk, arst_n,
		(state_q == larm_pkg::ST_DONE) && out_valid_q && !res.ready,
		state_q == larm_pkg::ST_DONE)
	`LARM_ASSERT_NEXT(a_point_keeps_max, clk, arst_n,
		done && point_op, rmax_q >= $past(rmax_q))

endmodule

// ===== dv/lazy_add_raise_table_with_max_unit_tb.sv =====
// Self-checking testbench for the lazy add/raise table with running maximum.
// Depends on larm_pkg, larm_if.sv and the lazy_add_raise_table_with_max_unit RTL.
`timescale 1ns / 100ps

typedef struct {
	logic signed [larm_pkg::DATA_W-1:0] max_value;
	logic signed [larm_pkg::DATA_W-1:0] entry_value;
} table_result_t;

// Tracks the table contents and lazy tags, and holds the results still owed by the unit.
class lazy_table_tracker;
	logic signed [larm_pkg::DATA_W-1:0] cells [larm_pkg::DEPTH_DEFAULT];
	logic signed [larm_pkg::DATA_W-1:0] floor_tag;
	logic signed [larm_pkg::DATA_W-1:0] shift_tag;
	logic signed [larm_pkg::DATA_W-1:0] peak;
	table_result_t                      owed_results[$];
	int                                 errors;
	int                                 checked;
	int                                 kind_count[4];

	function new();
		foreach (cells[i])
			cells[i] = '0;
		floor_tag = '0;
		shift_tag = '0;
		peak      = '0;
		errors    = 0;
		checked   = 0;
		foreach (kind_count[i])
			kind_count[i] = 0;
	endfunction

	function logic signed [larm_pkg::DATA_W-1:0] hi_of(logic signed [larm_pkg::DATA_W-1:0] a,
	                                                   logic signed [larm_pkg::DATA_W-1:0] b);
		return (a < b) ? b : a;
	endfunction

	function int pending();
		return owed_results.size();
	endfunction

	// Called for every accepted operation transfer.
	function void apply_op(larm_pkg::kind_t k, logic [larm_pkg::INDEX_W-1:0] idx,
	                       logic signed [larm_pkg::DATA_W-1:0] v);
		table_result_t                      r;
		logic signed [larm_pkg::DATA_W-1:0] lifted;
		r.entry_value = '0;
		kind_count[k]++;
		case (k)
			larm_pkg::KIND_ADD_ALL: begin
				shift_tag += v;
				peak      += v;
				floor_tag += v;
			end
			larm_pkg::KIND_RAISE_ALL: begin
				floor_tag = hi_of(floor_tag, v);
				peak      = hi_of(peak, floor_tag);
			end
			default: begin
				// with a 10-bit index and 1024 entries every index is in range
				if (idx < larm_pkg::DEPTH_DEFAULT) begin
					lifted = cells[idx] + shift_tag;
					if (lifted < floor_tag)
						cells[idx] = floor_tag - shift_tag;
					lifted = cells[idx] + shift_tag;
					if (k == larm_pkg::KIND_ADD_AT)
						cells[idx] = cells[idx] + v;
					else
						cells[idx] = hi_of(v, lifted) - shift_tag;
					lifted        = cells[idx] + shift_tag;
					peak          = hi_of(peak, lifted);
					r.entry_value = hi_of(lifted, floor_tag);
				end
			end
		endcase
		r.max_value = peak;
		owed_results.push_back(r);
	endfunction

	task flag_mismatch(string what, logic [larm_pkg::DATA_W-1:0] got,
	                   logic [larm_pkg::DATA_W-1:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		errors++;
	endtask

	// Called for every accepted result transfer.
	task compare_result(logic signed [larm_pkg::DATA_W-1:0] got_max,
	                    logic signed [larm_pkg::DATA_W-1:0] got_entry);
		table_result_t want;
		if (owed_results.size() == 0) begin
			flag_mismatch("unexpected result", got_max, '0);
		end else begin
			want = owed_results.pop_front();
			checked++;
			if (got_max !== want.max_value)
				flag_mismatch("max_value", got_max, want.max_value);
			if (got_entry !== want.entry_value)
				flag_mismatch("entry_value", got_entry, want.entry_value);
		end
	endtask
endclass

module lazy_add_raise_table_with_max_unit_tb;
	localparam int DW = larm_pkg::DATA_W;
	localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;

	lazy_table_tracker tracker;

	larm_in_if  op_if();
	larm_out_if res_if();

	lazy_add_raise_table_with_max_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_if),
		.res    (res_if)
	);

	always #2 clk = ~clk;

	// result side: check on transfer, then pick next ready at random
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			tracker.compare_result(res_if.max_value, res_if.entry_value);
		res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_op(input larm_pkg::kind_t k, input logic [larm_pkg::INDEX_W-1:0] idx,
	                       input logic signed [DW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			op_if.valid <= 1'b0;
			@(posedge clk);
		end
		op_if.valid <= 1'b1;
		op_if.kind  <= k;
		op_if.index <= idx;
		op_if.value <= v;
		@(posedge clk);
		while (!op_if.ready)
			@(posedge clk);
		tracker.apply_op(k, idx, v);
	endtask

	// hold off the sender until every owed result has come back
	task automatic drain();
		op_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] pick_value();
		logic signed [DW-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = DW'(int'($urandom_range(2000)) - 1000);
			4, 5:       v = DW'($signed($urandom));
			6: begin
				case ($urandom_range(3))
					0: v = VAL_MAX;
					1: v = VAL_MIN;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default:    v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [larm_pkg::INDEX_W-1:0] pick_index();
		// half the time one of 16 hot entries so point operations revisit them
		if ($urandom_range(1))
			return {$urandom_range(1) ? 7'h7f : 7'h00, 3'($urandom_range(7))};
		return larm_pkg::INDEX_W'($urandom);
	endfunction

	task automatic random_ops(input int count);
		larm_pkg::kind_t k;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1:    k = larm_pkg::KIND_ADD_ALL;
				2:       k = larm_pkg::KIND_RAISE_ALL;
				3, 4, 5: k = larm_pkg::KIND_ADD_AT;
				default: k = larm_pkg::KIND_RAISE_AT;
			endcase
			send_op(k, pick_index(), pick_value());
		end
	endtask

	initial begin
		tracker       = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n        = 1'b0;
		op_if.valid  <= 1'b0;
		op_if.kind   <= larm_pkg::KIND_ADD_ALL;
		op_if.index  <= '0;
		op_if.value  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every kind, max held after a negative point add, wrapping
		send_op(larm_pkg::KIND_RAISE_AT, 10'd0, 64'sd5);
		send_op(larm_pkg::KIND_ADD_AT, 10'd0, -64'sd10);
		send_op(larm_pkg::KIND_ADD_AT, 10'd1023, 64'sd1);
		send_op(larm_pkg::KIND_RAISE_ALL, 10'd0, 64'sd3);
		send_op(larm_pkg::KIND_ADD_AT, 10'd0, 64'sd0);
		send_op(larm_pkg::KIND_ADD_ALL, 10'd0, VAL_MAX);
		send_op(larm_pkg::KIND_ADD_ALL, 10'd0, 64'sd1);
		send_op(larm_pkg::KIND_RAISE_ALL, 10'd0, VAL_MIN);
		send_op(larm_pkg::KIND_RAISE_ALL, 10'd0, VAL_MAX);
		send_op(larm_pkg::KIND_RAISE_AT, 10'd1023, VAL_MIN);
		send_op(larm_pkg::KIND_ADD_AT, 10'd512, VAL_MAX);
		send_op(larm_pkg::KIND_ADD_AT, 10'd512, 64'sd1);
		send_op(larm_pkg::KIND_ADD_ALL, 10'd0, VAL_MIN);
		send_op(larm_pkg::KIND_RAISE_AT, 10'd512, VAL_MAX);
		send_op(larm_pkg::KIND_RAISE_ALL, 10'd0, 64'sd0);
		send_op(larm_pkg::KIND_ADD_ALL, 10'd0, -64'sd1);
		send_op(larm_pkg::KIND_ADD_AT, 10'd341, -64'sd1);
		send_op(larm_pkg::KIND_RAISE_AT, 10'd682, 64'sd0);
		send_op(larm_pkg::KIND_ADD_AT, 10'd1023, VAL_MIN);
		send_op(larm_pkg::KIND_RAISE_AT, 10'd0, {$urandom, $urandom});
		drain();

		send_idle_pct = 36;
		recv_idle_pct = 69;
		random_ops(600);
		drain();

		send_idle_pct = 69;
		recv_idle_pct = 36;
		random_ops(600);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_ops(550);
		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d transfers: %0d add-all, %0d raise-all, %0d add-at, %0d raise-at",
		         tracker.kind_count[0] + tracker.kind_count[1] + tracker.kind_count[2] +
		         tracker.kind_count[3], tracker.kind_count[0], tracker.kind_count[1],
		         tracker.kind_count[2], tracker.kind_count[3]);
		$display("%0d results checked, %0d mismatches", tracker.checked, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("[lazy_add_raise_table_with_max_unit] OK");
		end else begin
			$display("[lazy_add_raise_table_with_max_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", tracker.pending());
		$display("[lazy_add_raise_table_with_max_unit] ERROR");
		$finish;
	end
endmodule
